>>> rtl/etfd_pkg.sv
// ----------------------------------------------------------------------------
// etfd_pkg
// Shared types and constants of the event flag task dispatcher.
// ----------------------------------------------------------------------------
package etfd_pkg;

  localparam int MAX_TASKS  = 32;
  localparam int EVENT_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_TASKS);
  localparam int CNT_W      = $clog2(MAX_TASKS + 1);

  localparam logic [EVENT_BITS-1:0] EV_MASK = {EVENT_BITS{1'b1}};

  // request codes
  typedef enum logic [2:0] {
    OP_REGISTER   = 3'd0,
    OP_UNREGISTER = 3'd1,
    OP_SET        = 3'd2,
    OP_CLEAR      = 3'd3,
    OP_DISPATCH   = 3'd4,
    OP_COMPLETE   = 3'd5,
    OP_QUERY      = 3'd6
  } req_op_t;

  // status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_PARAM  = 2'd1,
    ST_NOFREE = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_FRD,
    S_FEV,
    S_REG_END,
    S_ORD_RD,
    S_ORD_EV,
    S_PEND_RD,
    S_PEND_WR,
    S_DRD_O,
    S_DRD_P,
    S_DEV,
    S_DFN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] func_id;
    logic [4:0]  task_handle;
    logic        handle_given;
    logic [15:0] event_mask;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  out_handle;
    logic        out_handle_valid;
    logic [15:0] out_events;
    logic [15:0] out_func_id;
    logic        idle_call;
  } rsp_t;

endpackage

>>> rtl/etfd_ram.sv
// ----------------------------------------------------------------------------
// etfd_ram
// Simple dual port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module etfd_ram #(
  parameter int W  = 16,
  parameter int D  = 32,
  parameter int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/etfd_ctrl.sv
// ----------------------------------------------------------------------------
// etfd_ctrl
// Sequencer that walks the slot table and order list one entry per step.
// ----------------------------------------------------------------------------
module etfd_ctrl
  import etfd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  input  logic idle_en,
  output logic busy,
  output logic done,
  output rsp_t result
);

  state_t                state, state_next;
  logic [CNT_W-1:0]      idx, idx_next;
  logic [IDX_W-1:0]      tgt, tgt_next;
  logic [IDX_W-1:0]      free_slot, free_slot_next;
  logic                  free_found, free_found_next;
  logic                  found, found_next;
  logic [EVENT_BITS-1:0] ev_hold, ev_hold_next;
  cmd_t                  c, c_next;
  logic [MAX_TASKS-1:0]  used, used_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [IDX_W-1:0]      active_slot, active_slot_next;
  logic                  active_valid, active_valid_next;
  rsp_t                  rsp, rsp_next;

  // memory ports
  logic                  fn_we, pd_we, od_we;
  logic [IDX_W-1:0]      fn_wa, pd_wa, od_wa, fn_ra, pd_ra, od_ra;
  logic [15:0]           fn_wd, fn_rd;
  logic [EVENT_BITS-1:0] pd_wd, pd_rd;
  logic [IDX_W-1:0]      od_wd, od_rd;

  etfd_ram #(.W(16), .D(MAX_TASKS)) u_func (
    .clk(clk), .we(fn_we), .waddr(fn_wa), .wdata(fn_wd), .raddr(fn_ra), .rdata(fn_rd)
  );
  etfd_ram #(.W(EVENT_BITS), .D(MAX_TASKS)) u_pend (
    .clk(clk), .we(pd_we), .waddr(pd_wa), .wdata(pd_wd), .raddr(pd_ra), .rdata(pd_rd)
  );
  etfd_ram #(.W(IDX_W), .D(MAX_TASKS)) u_order (
    .clk(clk), .we(od_we), .waddr(od_wa), .wdata(od_wd), .raddr(od_ra), .rdata(od_rd)
  );

  assign busy   = (state != S_IDLE);
  assign done   = (state == S_DONE);
  assign result = rsp;

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      used         <= '0;
      count        <= '0;
      active_slot  <= '0;
      active_valid <= 1'b0;
    end else begin
      state        <= state_next;
      used         <= used_next;
      count        <= count_next;
      active_slot  <= active_slot_next;
      active_valid <= active_valid_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    tgt        <= tgt_next;
    free_slot  <= free_slot_next;
    free_found <= free_found_next;
    found      <= found_next;
    ev_hold    <= ev_hold_next;
    c          <= c_next;
    rsp        <= rsp_next;
  end

  // next state and memory control
  always_comb begin
    logic [IDX_W-1:0] s;
    logic [IDX_W-1:0] ix;
    state_next        = state;
    idx_next          = idx;
    tgt_next          = tgt;
    free_slot_next    = free_slot;
    free_found_next   = free_found;
    found_next        = found;
    ev_hold_next      = ev_hold;
    c_next            = c;
    used_next         = used;
    count_next        = count;
    active_slot_next  = active_slot;
    active_valid_next = active_valid;
    rsp_next          = rsp;
    fn_we = 1'b0; fn_wa = '0; fn_wd = '0; fn_ra = '0;
    pd_we = 1'b0; pd_wa = '0; pd_wd = '0; pd_ra = '0;
    od_we = 1'b0; od_wa = '0; od_wd = '0; od_ra = '0;
    s  = '0;
    ix = idx[IDX_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (start) begin
          c_next          = cmd;
          c_next.event_mask = cmd.event_mask & EV_MASK;
          idx_next        = '0;
          found_next      = 1'b0;
          free_found_next = 1'b0;
          rsp_next        = '0;
          state_next      = S_DONE;
          case (cmd.req_type) inside
            OP_REGISTER: begin
              if (cmd.func_id == '0) rsp_next.status = ST_PARAM;
              else state_next = S_FRD;
            end
            OP_UNREGISTER: begin
              s = cmd.handle_given ? cmd.task_handle : active_slot;
              if ((!cmd.handle_given && !active_valid) || !used[s]) begin
                rsp_next.status = ST_PARAM;
              end else begin
                tgt_next   = s;
                state_next = S_ORD_RD;
              end
            end
            OP_SET, OP_CLEAR: begin
              if (!cmd.handle_given || !used[cmd.task_handle]) begin
                rsp_next.status = ST_PARAM;
              end else begin
                tgt_next   = cmd.task_handle;
                state_next = S_PEND_RD;
              end
            end
            OP_DISPATCH: state_next = S_DRD_O;
            OP_COMPLETE: begin
              if (!active_valid) begin
                rsp_next.status = ST_PARAM;
              end else begin
                active_valid_next = 1'b0;
                if (!used[active_slot]) begin
                  rsp_next.status = ST_PARAM;
                end else begin
                  tgt_next   = active_slot;
                  state_next = S_PEND_RD;
                end
              end
            end
            OP_QUERY: begin
              if (active_valid) begin
                rsp_next.out_handle       = active_slot;
                rsp_next.out_handle_valid = 1'b1;
              end
            end
            default: rsp_next.status = ST_PARAM;
          endcase
        end
      end

      // register: scan every slot until a match, tracking the lowest free one
      S_FRD: begin
        fn_ra      = ix;
        state_next = S_FEV;
      end
      S_FEV: begin
        if (used[ix] && fn_rd == c.func_id) begin
          rsp_next.out_handle       = ix;
          rsp_next.out_handle_valid = 1'b1;
          state_next                = S_DONE;
        end else begin
          if (!used[ix] && !free_found) begin
            free_found_next = 1'b1;
            free_slot_next  = ix;
          end
          if (idx == CNT_W'(MAX_TASKS - 1)) begin
            state_next = S_REG_END;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_FRD;
          end
        end
      end
      S_REG_END: begin
        if (!free_found || count >= CNT_W'(MAX_TASKS)) begin
          rsp_next.status = ST_NOFREE;
        end else begin
          fn_we = 1'b1; fn_wa = free_slot; fn_wd = c.func_id;
          pd_we = 1'b1; pd_wa = free_slot; pd_wd = '0;
          od_we = 1'b1; od_wa = count[IDX_W-1:0]; od_wd = free_slot;
          used_next[free_slot]      = 1'b1;
          count_next                = count + 1'b1;
          rsp_next.out_handle       = free_slot;
          rsp_next.out_handle_valid = 1'b1;
        end
        state_next = S_DONE;
      end

      // unregister: walk the order list, shift entries after the target down
      S_ORD_RD: begin
        if (idx == count) begin
          if (found) count_next = count - 1'b1;
          used_next[tgt] = 1'b0;
          state_next     = S_DONE;
        end else begin
          od_ra      = ix;
          state_next = S_ORD_EV;
        end
      end
      S_ORD_EV: begin
        if (found) begin
          od_we = 1'b1;
          od_wa = IDX_W'(idx - 1'b1);
          od_wd = od_rd;
        end
        if (od_rd == tgt) found_next = 1'b1;
        idx_next   = idx + 1'b1;
        state_next = S_ORD_RD;
      end

      // set, clear and complete: read-modify-write of the pending mask
      S_PEND_RD: begin
        pd_ra      = tgt;
        state_next = S_PEND_WR;
      end
      S_PEND_WR: begin
        pd_we = 1'b1;
        pd_wa = tgt;
        if (c.req_type == OP_CLEAR) pd_wd = pd_rd & ~c.event_mask;
        else pd_wd = pd_rd | c.event_mask;
        state_next = S_DONE;
      end

      // dispatch: first entry in order with pending events
      S_DRD_O: begin
        if (idx == count) begin
          rsp_next.idle_call = idle_en;
          state_next         = S_DONE;
        end else begin
          od_ra      = ix;
          state_next = S_DRD_P;
        end
      end
      S_DRD_P: begin
        tgt_next   = od_rd;
        pd_ra      = od_rd;
        state_next = S_DEV;
      end
      S_DEV: begin
        if (pd_rd != '0) begin
          pd_we = 1'b1; pd_wa = tgt; pd_wd = '0;
          fn_ra             = tgt;
          ev_hold_next      = pd_rd;
          active_slot_next  = tgt;
          active_valid_next = 1'b1;
          state_next        = S_DFN;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_DRD_O;
        end
      end
      S_DFN: begin
        rsp_next.out_handle       = tgt;
        rsp_next.out_handle_valid = 1'b1;
        rsp_next.out_events       = 16'(ev_hold);
        rsp_next.out_func_id      = fn_rd;
        state_next                = S_DONE;
      end

      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/event_flag_task_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// event_flag_task_dispatcher_unit
// Fixed priority event flag task dispatcher with a small request sequencer.
// ----------------------------------------------------------------------------
// One request is taken when start is high and busy is low; its result beat
// shows on result for one cycle with done high, and must be taken then.
// The sequencer steps through the slot memories, which have one registered
// read port each. Register makes a full scan of the function table for a new
// id, and a match ends the scan early; unregister walks the whole order list;
// dispatch visits list entries in order until one has pending events. No new
// request is taken while busy is high.
module event_flag_task_dispatcher_unit
  import etfd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic done,
  output rsp_t result,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  logic idle_en;

  // idle handler enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_en <= 1'b0;
    end else if (cfg_we) begin
      idle_en <= cfg_wdata;
    end
  end

  // request sequencer
  etfd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .idle_en(idle_en),
    .busy(busy), .done(done), .result(result)
  );

  // checks
  a_acc_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted request did not raise busy");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result beat outside busy");
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy held after result beat");
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status != 2'd3)) else $error("bad status code");

endmodule
